[rtl/mppr_pkg.sv]
// ----------------------------------------------------------------------------
// mppr_pkg
// Shared constants, types and helpers for the multi-policy page table.
// ----------------------------------------------------------------------------
package mppr_pkg;

	localparam int unsigned ENTRIES       = 16;
	localparam int unsigned KEY_BITS      = 10;
	localparam int unsigned COUNT_BITS    = 16;
	localparam int unsigned IDX_BITS      = $clog2(ENTRIES);
	localparam int unsigned SLOT_BITS     = $clog2(ENTRIES + 1);
	localparam int unsigned HIST_DEPTH    = 1 << KEY_BITS;
	localparam int unsigned POLICY_BITS   = 2;
	localparam int unsigned CFG_IDX_BITS  = 1;
	localparam int unsigned CFG_DATA_BITS = SLOT_BITS;

	typedef enum logic [POLICY_BITS-1:0] {
		POL_LRU = 2'd0,
		POL_LFU = 2'd1,
		POL_MRU = 2'd2,
		POL_MFU = 2'd3
	} policy_t;

	localparam logic [CFG_IDX_BITS-1:0] CFG_POLICY = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT  = 1'b1;

	localparam policy_t               POLICY_RESET = POL_LFU;
	localparam logic [SLOT_BITS-1:0] LIMIT_RESET  = SLOT_BITS'(ENTRIES);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	// what the victim compare looks at for one entry
	typedef struct packed {
		logic [COUNT_BITS-1:0] count;
		logic [IDX_BITS-1:0]   rank;
	} cand_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		logic [COUNT_BITS-1:0] r;
		r = (c == '1) ? c : c + COUNT_BITS'(1);
		return r;
	endfunction

endpackage

[rtl/mppr_ram.sv]
// ----------------------------------------------------------------------------
// mppr_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module mppr_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[rtl/mppr_pick.sv]
// ----------------------------------------------------------------------------
// mppr_pick
// Victim compare: does the candidate beat the current best under the policy.
// ----------------------------------------------------------------------------
module mppr_pick (
	input  mppr_pkg::policy_t policy,
	input  mppr_pkg::cand_t   cand,
	input  mppr_pkg::cand_t   best,
	output logic              take
);
	import mppr_pkg::*;

	logic cnt_lt;
	logic cnt_eq;
	logic older;

	assign cnt_lt = cand.count < best.count;
	assign cnt_eq = cand.count == best.count;
	assign older  = cand.rank > best.rank;

	always_comb begin
		case (policy)
			POL_LRU: take = older;
			POL_LFU: take = cnt_lt || (cnt_eq && older);
			POL_MRU: take = cand.rank < best.rank;
			POL_MFU: take = (!cnt_lt && !cnt_eq) || (cnt_eq && older);
			default: take = 1'b0;
		endcase
	end

endmodule

[rtl/multi_policy_page_replacement.sv]
// ----------------------------------------------------------------------------
// multi_policy_page_replacement
// Fully associative page table with LRU / LFU / MRU / MFU eviction.
// ----------------------------------------------------------------------------
// After reset the block zeroes its 1024-entry count memory, one entry a
// cycle, and holds in_stall high until that clear is done; configuration writes
// are taken throughout. Each page access then accepts the beat, walks the
// table entry by entry with a single compare unit that does the key match
// and the victim search together, and in the update state writes the table,
// the count memory and the result register. The update cycle
// waits while a previous result is still held on a stalled output.
module multi_policy_page_replacement (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [mppr_pkg::KEY_BITS-1:0]        page_key,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 hit,
	output logic [mppr_pkg::SLOT_BITS-1:0]       slot,
	output logic                                 evicted_valid,
	output logic [mppr_pkg::KEY_BITS-1:0]        evicted_key,
	input  logic                                 cfg_we,
	input  logic [mppr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [mppr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import mppr_pkg::*;

	state_t state_q, state_d;
	logic   accept, commit, clearing;

	policy_t              policy_q;
	logic [SLOT_BITS-1:0] limit_q;
	logic [SLOT_BITS-1:0] lim_eff;

	logic                  entry_valid_q [ENTRIES];
	logic [KEY_BITS-1:0]   entry_key_q   [ENTRIES];
	logic [COUNT_BITS-1:0] entry_count_q [ENTRIES];
	logic [IDX_BITS-1:0]   entry_rank_q  [ENTRIES];
	logic [SLOT_BITS-1:0]  occ_q;

	logic [KEY_BITS-1:0]   clr_q;
	logic [IDX_BITS-1:0]   scan_q;
	logic [KEY_BITS-1:0]   key_q;
	logic                  found_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [IDX_BITS-1:0]   old_rank_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic                  have_q;
	logic [IDX_BITS-1:0]   best_idx_q;
	logic [KEY_BITS-1:0]   best_key_q;
	cand_t                 best_q;
	cand_t                 cand;
	logic                  take;
	logic                  match;

	logic                  miss_free;
	logic                  evict;
	logic [IDX_BITS-1:0]   tgt;
	logic [SLOT_BITS-1:0]  orank;
	logic [COUNT_BITS-1:0] new_cnt;

	logic                  ram_we;
	logic [KEY_BITS-1:0]   ram_addr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [COUNT_BITS-1:0] ram_rdata;

	logic                  out_valid_q;
	logic                  hit_q;
	logic [SLOT_BITS-1:0]  slot_q;
	logic                  ev_valid_q;
	logic [KEY_BITS-1:0]   ev_key_q;

	// count memory
	mppr_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(HIST_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// shared victim compare
	assign cand.count = entry_count_q[scan_q];
	assign cand.rank  = entry_rank_q[scan_q];

	mppr_pick u_pick (
		.policy(policy_q),
		.cand  (cand),
		.best  (best_q),
		.take  (take)
	);

	assign match = entry_valid_q[scan_q] && (entry_key_q[scan_q] == key_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		accept  = 1'b0;
		commit  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					accept  = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_q == '1) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (!out_valid_q || !out_stall) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall = state_q != ST_IDLE;
	assign clearing = state_q == ST_CLEAR;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_RESET;
			limit_q  <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POLICY: policy_q <= policy_t'(cfg_data[POLICY_BITS-1:0]);
				CFG_LIMIT:  limit_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_comb begin
		if (limit_q == '0) begin
			lim_eff = SLOT_BITS'(1);
		end else if (limit_q > SLOT_BITS'(ENTRIES)) begin
			lim_eff = SLOT_BITS'(ENTRIES);
		end else begin
			lim_eff = limit_q;
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			scan_q  <= '0;
			found_q <= 1'b0;
			have_q  <= 1'b0;
		end else begin
			if (clearing) begin
				clr_q <= clr_q + KEY_BITS'(1);
			end
			if (accept) begin
				scan_q  <= '0;
				found_q <= 1'b0;
				have_q  <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				scan_q <= scan_q + IDX_BITS'(1);
				if (match) begin
					found_q <= 1'b1;
				end
				if (entry_valid_q[scan_q]) begin
					have_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= page_key;
		end
		if (state_q == ST_SCAN) begin
			if (match && !found_q) begin
				idx_q      <= scan_q;
				old_rank_q <= entry_rank_q[scan_q];
				hit_cnt_q  <= entry_count_q[scan_q];
			end
			if (entry_valid_q[scan_q] && (!have_q || take)) begin
				best_idx_q <= scan_q;
				best_key_q <= entry_key_q[scan_q];
				best_q     <= cand;
			end
		end
	end

	// update decision
	assign miss_free = occ_q < lim_eff;
	assign evict     = !found_q && !miss_free;

	always_comb begin
		if (found_q) begin
			tgt     = idx_q;
			orank   = SLOT_BITS'(old_rank_q);
			new_cnt = sat_inc(hit_cnt_q);
		end else if (miss_free) begin
			tgt     = occ_q[IDX_BITS-1:0];
			orank   = SLOT_BITS'(ENTRIES);
			new_cnt = sat_inc(ram_rdata);
		end else begin
			tgt     = best_idx_q;
			orank   = SLOT_BITS'(best_q.rank);
			new_cnt = sat_inc(ram_rdata);
		end
	end

	assign ram_we    = clearing || commit;
	assign ram_wdata = clearing ? '0 : new_cnt;
	always_comb begin
		if (clearing) begin
			ram_addr = clr_q;
		end else if (state_q == ST_IDLE) begin
			ram_addr = page_key;
		end else begin
			ram_addr = key_q;
		end
	end

	// table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				entry_valid_q[i] <= 1'b0;
			end
			occ_q <= '0;
		end else if (commit) begin
			entry_valid_q[tgt] <= 1'b1;
			if (!found_q && miss_free) begin
				occ_q <= occ_q + SLOT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (entry_valid_q[i] && IDX_BITS'(i) != tgt &&
				    SLOT_BITS'(entry_rank_q[i]) < orank) begin
					entry_rank_q[i] <= entry_rank_q[i] + IDX_BITS'(1);
				end
			end
			entry_rank_q[tgt]  <= '0;
			entry_key_q[tgt]   <= key_q;
			entry_count_q[tgt] <= new_cnt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hit_q      <= found_q;
			slot_q     <= SLOT_BITS'(tgt) + SLOT_BITS'(1);
			ev_valid_q <= evict;
			ev_key_q   <= evict ? best_key_q : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign slot          = slot_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_key   = ev_key_q;

	// checks
	a_out_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_UPDATE))
		else $error("result beat without an update cycle");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && hit_q |-> !ev_valid_q && ev_key_q == '0)
		else $error("hit beat reports an eviction");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= SLOT_BITS'(ENTRIES))
		else $error("occupancy above table size");

	a_evict_has_victim: assert property (@(posedge clk) disable iff (!arst_n)
		commit && evict |-> have_q && occ_q != '0)
		else $error("eviction with an empty table");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> slot_q != '0 && slot_q <= SLOT_BITS'(ENTRIES))
		else $error("slot out of range");

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-policy page table. A short directed table
// covers the key extremes, all four eviction policies, and limits of zero,
// one, full and above full, including a limit dropped below occupancy. A long
// random run follows in phases, each with a new setting and a small working
// set of pages. Every result beat is checked against fixed values or a local
// model of the table, its recency order and the per-page use count memory.
// ----------------------------------------------------------------------------
module testbench;
	import mppr_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 600000;
	localparam int unsigned RANDOM_ITEMS = 1900;
	localparam int unsigned ROWS         = 24;
	localparam int unsigned DRAIN_CYCLES = 40;

	typedef enum logic {ROW_PAGE, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic                 hit;
		logic [SLOT_BITS-1:0] slot;
		logic                 ev_valid;
		logic [KEY_BITS-1:0]  ev_key;
	} access_result_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [CFG_IDX_BITS-1:0]  reg_sel;
		logic [CFG_DATA_BITS-1:0] data;
		logic [KEY_BITS-1:0]      key;
		logic                     fixed;
		access_result_t           want;
	} stim_row_t;

	localparam access_result_t NO_WANT = '0;

	localparam stim_row_t DIRECTED_ROWS [ROWS] = '{
		'{ROW_PAGE, CFG_POLICY, '0, 10'd0,    1'b1, '{1'b0, 5'd1, 1'b0, 10'd0}},
		'{ROW_PAGE, CFG_POLICY, '0, 10'd1023, 1'b1, '{1'b0, 5'd2, 1'b0, 10'd0}},
		'{ROW_PAGE, CFG_POLICY, '0, 10'd0,    1'b1, '{1'b1, 5'd1, 1'b0, 10'd0}},
		'{ROW_PAGE, CFG_POLICY, '0, 10'd341,  1'b1, '{1'b0, 5'd3, 1'b0, 10'd0}},
		'{ROW_PAGE, CFG_POLICY, '0, 10'd682,  1'b1, '{1'b0, 5'd4, 1'b0, 10'd0}},
		'{ROW_CFG,  CFG_LIMIT,  5'd0, '0,     1'b0, NO_WANT},
		'{ROW_PAGE, CFG_POLICY, '0, 10'd5,    1'b0, NO_WANT},
		'{ROW_CFG,  CFG_POLICY, CFG_DATA_BITS'(POL_LRU), '0, 1'b0, NO_WANT},
		'{ROW_PAGE, CFG_POLICY, '0, 10'd6,    1'b0, NO_WANT},
		'{ROW_CFG,  CFG_POLICY, CFG_DATA_BITS'(POL_MRU), '0, 1'b0, NO_WANT},
		'{ROW_PAGE, CFG_POLICY, '0, 10'd7,    1'b0, NO_WANT},
		'{ROW_PAGE, CFG_POLICY, '0, 10'd7,    1'b0, NO_WANT},
		'{ROW_CFG,  CFG_POLICY, CFG_DATA_BITS'(POL_MFU), '0, 1'b0, NO_WANT},
		'{ROW_PAGE, CFG_POLICY, '0, 10'd8,    1'b0, NO_WANT},
		'{ROW_CFG,  CFG_LIMIT,  5'd31, '0,    1'b0, NO_WANT},
		'{ROW_PAGE, CFG_POLICY, '0, 10'd1023, 1'b0, NO_WANT},
		'{ROW_PAGE, CFG_POLICY, '0, 10'd9,    1'b0, NO_WANT},
		'{ROW_PAGE, CFG_POLICY, '0, 10'd682,  1'b0, NO_WANT},
		'{ROW_CFG,  CFG_LIMIT,  5'd16, '0,    1'b0, NO_WANT},
		'{ROW_PAGE, CFG_POLICY, '0, 10'd10,   1'b0, NO_WANT},
		'{ROW_CFG,  CFG_LIMIT,  5'd1, '0,     1'b0, NO_WANT},
		'{ROW_PAGE, CFG_POLICY, '0, 10'd11,   1'b0, NO_WANT},
		'{ROW_CFG,  CFG_POLICY, CFG_DATA_BITS'(POL_LFU), '0, 1'b0, NO_WANT},
		'{ROW_PAGE, CFG_POLICY, '0, 10'd0,    1'b0, NO_WANT}
	};

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [KEY_BITS-1:0]      page_key;
	logic                     out_valid;
	logic                     out_stall;
	logic                     hit;
	logic [SLOT_BITS-1:0]     slot;
	logic                     evicted_valid;
	logic [KEY_BITS-1:0]      evicted_key;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	// model of the page table
	logic                  pt_valid [ENTRIES];
	logic [KEY_BITS-1:0]   pt_key   [ENTRIES];
	logic [COUNT_BITS-1:0] pt_count [ENTRIES];
	int unsigned           pt_rank  [ENTRIES];
	int unsigned           pt_fill;
	logic [COUNT_BITS-1:0] use_hist [HIST_DEPTH];
	policy_t               cur_policy;
	logic [SLOT_BITS-1:0]  cur_limit;

	access_result_t pending_results [$];
	int unsigned    error_count = 0;
	int unsigned    cycle_count = 0;

	multi_policy_page_replacement i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	// entry idx becomes newest, everything newer than old_rank ages by one
	function automatic void promote(input int unsigned idx, input int unsigned old_rank);
		for (int unsigned i = 0; i < ENTRIES; i++) begin
			if (i != idx && pt_valid[i] && pt_rank[i] < old_rank) begin
				pt_rank[i]++;
			end
		end
		pt_rank[idx] = 0;
	endfunction

	function automatic int unsigned victim_entry();
		int unsigned best;
		bit          have;
		bit          take;
		best = 0;
		have = 1'b0;
		for (int unsigned i = 0; i < ENTRIES; i++) begin
			if (!pt_valid[i]) begin
				continue;
			end
			if (!have) begin
				best = i;
				have = 1'b1;
				continue;
			end
			case (cur_policy)
				POL_LRU: take = pt_rank[i] > pt_rank[best];
				POL_LFU: take = pt_count[i] < pt_count[best] ||
					(pt_count[i] == pt_count[best] && pt_rank[i] > pt_rank[best]);
				POL_MRU: take = pt_rank[i] < pt_rank[best];
				default: take = pt_count[i] > pt_count[best] ||
					(pt_count[i] == pt_count[best] && pt_rank[i] > pt_rank[best]);
			endcase
			if (take) begin
				best = i;
			end
		end
		return best;
	endfunction

	function automatic access_result_t predict_access(input logic [KEY_BITS-1:0] key);
		access_result_t res;
		int unsigned    lim;
		int unsigned    idx;
		int unsigned    old_rank;
		bit             found;
		res = '0;
		found = 1'b0;
		idx = 0;
		lim = cur_limit;
		if (lim == 0) begin
			lim = 1;
		end
		if (lim > ENTRIES) begin
			lim = ENTRIES;
		end
		for (int unsigned i = 0; i < ENTRIES; i++) begin
			if (!found && pt_valid[i] && pt_key[i] == key) begin
				idx = i;
				found = 1'b1;
			end
		end
		if (found) begin
			pt_count[idx] = count_up(pt_count[idx]);
			use_hist[key] = pt_count[idx];
			promote(idx, pt_rank[idx]);
		end else begin
			if (pt_fill < lim) begin
				idx = pt_fill;
				pt_fill++;
				old_rank = ENTRIES;
			end else begin
				idx = victim_entry();
				res.ev_valid = 1'b1;
				res.ev_key = pt_key[idx];
				old_rank = pt_rank[idx];
			end
			use_hist[key] = count_up(use_hist[key]);
			pt_valid[idx] = 1'b1;
			pt_key[idx] = key;
			pt_count[idx] = use_hist[key];
			promote(idx, old_rank);
		end
		res.hit = found;
		res.slot = SLOT_BITS'(idx + 1);
		return res;
	endfunction

	task automatic set_reg(input logic [CFG_IDX_BITS-1:0] sel,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_we = 1'b1;
		cfg_index = sel;
		cfg_data = value;
		if (sel == CFG_POLICY) begin
			cur_policy = policy_t'(value[POLICY_BITS-1:0]);
		end else begin
			cur_limit = value;
		end
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain();
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_page(input logic [KEY_BITS-1:0] key, input logic fixed,
			input access_result_t want);
		access_result_t guess;
		in_valid = 1'b1;
		page_key = key;
		do @(posedge clk); while (in_stall);
		guess = predict_access(key);
		pending_results.insert(pending_results.size(), fixed ? want : guess);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		access_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				error_count++;
			end else begin
				exp_res = pending_results[0];
				pending_results.delete(0);
				if (hit !== exp_res.hit) begin
					$error("hit: expected %0d, got %0d", exp_res.hit, hit);
					error_count++;
				end
				if (slot !== exp_res.slot) begin
					$error("slot: expected %0d, got %0d", exp_res.slot, slot);
					error_count++;
				end
				if (evicted_valid !== exp_res.ev_valid) begin
					$error("evicted_valid: expected %0d, got %0d", exp_res.ev_valid,
						evicted_valid);
					error_count++;
				end
				if (evicted_key !== exp_res.ev_key) begin
					$error("evicted_key: expected %0d, got %0d", exp_res.ev_key,
						evicted_key);
					error_count++;
				end
			end
		end
	end

	// receiver stalls in randomly chosen modes, each held for a random span
	initial begin
		int unsigned mode;
		int unsigned span;
		int unsigned tick;
		out_stall = 1'b0;
		tick = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(50, 400);
			repeat (span) begin
				@(negedge clk);
				tick++;
				case (mode)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 3) == 0);
					2: out_stall = ($urandom_range(0, 1) == 0);
					default: out_stall = (tick % 11) < 5;
				endcase
			end
		end
	end

	initial begin
		int unsigned              sent;
		int unsigned              phase;
		int unsigned              phase_len;
		int unsigned              burst_left;
		int unsigned              pool_n;
		logic [KEY_BITS-1:0]      pool [32];
		logic [KEY_BITS-1:0]      key;
		logic [CFG_DATA_BITS-1:0] lim_val;

		arst_n = 1'b0;
		in_valid = 1'b0;
		page_key = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_POLICY;
		cfg_data = '0;
		for (int unsigned i = 0; i < ENTRIES; i++) begin
			pt_valid[i] = 1'b0;
			pt_key[i] = '0;
			pt_count[i] = '0;
			pt_rank[i] = 0;
		end
		for (int unsigned i = 0; i < HIST_DEPTH; i++) begin
			use_hist[i] = '0;
		end
		pt_fill = 0;
		cur_policy = POLICY_RESET;
		cur_limit = LIMIT_RESET;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED_ROWS[r]) begin
			if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
				in_valid = 1'b0;
				drain();
				set_reg(DIRECTED_ROWS[r].reg_sel, DIRECTED_ROWS[r].data);
			end else begin
				send_page(DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].fixed,
					DIRECTED_ROWS[r].want);
			end
		end
		in_valid = 1'b0;

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			drain();
			set_reg(CFG_POLICY, CFG_DATA_BITS'(policy_t'(phase % 4)));
			case ($urandom_range(0, 5))
				0: lim_val = '0;
				1: lim_val = CFG_DATA_BITS'(1);
				2: lim_val = CFG_DATA_BITS'(ENTRIES);
				3: lim_val = '1;
				default: lim_val = CFG_DATA_BITS'($urandom_range(2, ENTRIES - 1));
			endcase
			set_reg(CFG_LIMIT, lim_val);
			// working set around the capacity, sometimes just two hot pages
			pool_n = ($urandom_range(0, 7) == 0) ? 2 : $urandom_range(2, 24);
			for (int unsigned i = 0; i < pool_n; i++) begin
				pool[i] = KEY_BITS'($urandom);
			end
			phase_len = $urandom_range(40, 160);
			burst_left = 0;
			repeat (phase_len) begin
				if (burst_left == 0) begin
					in_valid = 1'b0;
					if ($urandom_range(0, 3) != 0) begin
						repeat ($urandom_range(1, 8)) @(negedge clk);
					end
					burst_left = $urandom_range(1, 16);
				end
				if ($urandom_range(0, 4) == 0) begin
					key = KEY_BITS'($urandom);
				end else begin
					key = pool[$urandom_range(0, pool_n - 1)];
				end
				send_page(key, 1'b0, NO_WANT);
				burst_left--;
				sent++;
			end
			in_valid = 1'b0;
			phase++;
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/mppr_pkg.sv
rtl/mppr_ram.sv
rtl/mppr_pick.sv
rtl/multi_policy_page_replacement.sv
bench/testbench.sv
